// File: src/bmx_pkg.sv
// bmx_pkg: shared codes and control/status types for the binary trie max-XOR block.
// No dependencies; imported by bmx_ctrl, bmx_dp and binary_trie_max_xor_top.
package bmx_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] stat_t;
	typedef logic [2:0] mode_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_QUERY  = 2'd2;
	localparam op_t OP_CLEAR  = 2'd3;

	localparam stat_t STAT_OK     = 2'd0;
	localparam stat_t STAT_EMPTY  = 2'd1;
	localparam stat_t STAT_ABSENT = 2'd2;
	localparam stat_t STAT_FULL   = 2'd3;

	localparam mode_t M_PROBE_INS = 3'd0;
	localparam mode_t M_UPD_INS   = 3'd1;
	localparam mode_t M_PROBE_REM = 3'd2;
	localparam mode_t M_UPD_REM   = 3'd3;
	localparam mode_t M_QUERY     = 3'd4;

	typedef struct packed {
		logic  load;
		logic  restart;
		logic  root_inc;
		logic  root_dec;
		logic  rd;
		logic  ex;
		logic  clear;
		logic  pub;
		logic  pub_ans;
		mode_t mode;
	} cmd_t;

	typedef struct packed {
		logic walk_end;
		logic root_empty;
		logic root_full;
		logic pool_fail;
		logic absent;
	} sts_t;

endpackage

// File: src/bmx_req_if.sv
// bmx_req_if: request channel (opcode and key) with valid/ready handshake.
// Depends on nothing; the key width follows KEY_BITS.
interface bmx_req_if #(parameter int KEY_BITS = 31);
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink (input valid, input opcode, input key, output ready);
endinterface

// File: src/bmx_rsp_if.sv
// bmx_rsp_if: response channel (best_xor and status) with valid/ready handshake.
// Depends on nothing; the best_xor width follows KEY_BITS.
interface bmx_rsp_if #(parameter int KEY_BITS = 31);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] best_xor;
	logic [1:0]          status;

	modport source (output valid, output best_xor, output status, input ready);
	modport sink (input valid, input best_xor, input status, output ready);
endinterface

// File: src/bmx_dp.sv
// bmx_dp: trie datapath - node memory, root entry, free pointer and walk registers.
// Depends on bmx_pkg; driven by bmx_ctrl through cmd_t, reports through sts_t.
module bmx_dp #(
	parameter int KEY_BITS   = 31,
	parameter int POOL_NODES = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bmx_pkg::cmd_t       cmd,
	output bmx_pkg::sts_t       sts,
	input  logic [KEY_BITS-1:0] key,
	output logic [KEY_BITS-1:0] best_xor
);
	import bmx_pkg::*;

	localparam int NODE_W = $clog2(POOL_NODES);
	localparam int FREE_W = NODE_W + 1;
	localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int MISS_W = $clog2(KEY_BITS + 1);
	localparam int SUM_W  = ((FREE_W > MISS_W) ? FREE_W : MISS_W) + 1;
	localparam int ENT_W  = 2 * NODE_W + 2 * COUNT_BITS;

	logic [ENT_W-1:0]      node_mem_q [POOL_NODES];
	logic [ENT_W-1:0]      rdata_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   ans_q;
	logic [KEY_BITS-1:0]   best_q;
	logic [NODE_W-1:0]     node_q;
	logic [LVL_W-1:0]      lvl_q;
	logic [MISS_W-1:0]     miss_q;
	logic                  fresh_q;
	logic                  absent_q;
	logic [FREE_W-1:0]     nfree_q;
	logic [NODE_W-1:0]     root_l0_q, root_l1_q;
	logic [COUNT_BITS-1:0] root_c0_q, root_c1_q, root_cnt_q;

	logic [NODE_W-1:0]     l0, l1, sel_l, oth_l, upd_l, q_nxt, nxt;
	logic [COUNT_BITS-1:0] c0, c1, sel_c, oth_c, upd_c;
	logic [NODE_W-1:0]     n_l0, n_l1;
	logic [COUNT_BITS-1:0] n_c0, n_c1;
	logic [KEY_BITS-1:0]   ans_nx;
	logic                  side, last, take, alloc, stop, upd, wr, is_root;

	always_comb begin
		is_root = (node_q == '0);
		if (is_root) begin
			l0 = root_l0_q;
			l1 = root_l1_q;
			c0 = root_c0_q;
			c1 = root_c1_q;
		end else if (fresh_q) begin
			l0 = '0;
			l1 = '0;
			c0 = '0;
			c1 = '0;
		end else begin
			l0 = rdata_q[NODE_W-1:0];
			l1 = rdata_q[2*NODE_W-1:NODE_W];
			c0 = rdata_q[2*NODE_W+COUNT_BITS-1:2*NODE_W];
			c1 = rdata_q[ENT_W-1:2*NODE_W+COUNT_BITS];
		end
		side  = key_q[lvl_q];
		last  = (lvl_q == '0);
		sel_l = side ? l1 : l0;
		sel_c = side ? c1 : c0;
		oth_l = side ? l0 : l1;
		oth_c = side ? c0 : c1;
		take  = (oth_c != '0);
		q_nxt = take ? oth_l : sel_l;
		alloc = (cmd.mode == M_UPD_INS) && (sel_l == '0);
		upd_l = alloc ? nfree_q[NODE_W-1:0] : sel_l;
		upd_c = (cmd.mode == M_UPD_INS) ? sel_c + COUNT_BITS'(1) : sel_c - COUNT_BITS'(1);
		n_l0  = side ? l0 : upd_l;
		n_l1  = side ? upd_l : l1;
		n_c0  = side ? c0 : upd_c;
		n_c1  = side ? upd_c : c1;
		upd   = (cmd.mode == M_UPD_INS) || (cmd.mode == M_UPD_REM);
		wr    = cmd.ex && upd;
		unique case (cmd.mode)
			M_PROBE_INS: stop = (sel_l == '0);
			M_PROBE_REM: stop = (sel_l == '0) || (last && sel_c == '0);
			M_QUERY:     stop = (q_nxt == '0);
			default:     stop = 1'b0;
		endcase
		nxt    = (cmd.mode == M_QUERY) ? q_nxt : upd_l;
		ans_nx = ans_q;
		if (cmd.ex && cmd.mode == M_QUERY && take) begin
			ans_nx = ans_q | (KEY_BITS'(1) << lvl_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= node_mem_q[node_q];
		end
		if (wr && !is_root) begin
			node_mem_q[node_q] <= {n_c1, n_c0, n_l1, n_l0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key;
			ans_q    <= '0;
			miss_q   <= '0;
			absent_q <= 1'b0;
		end else if (cmd.ex) begin
			ans_q <= ans_nx;
			if (stop && cmd.mode == M_PROBE_INS) begin
				miss_q <= MISS_W'(lvl_q) + MISS_W'(1);
			end
			if (stop && cmd.mode == M_PROBE_REM) begin
				absent_q <= 1'b1;
			end
		end
		if (cmd.load || cmd.restart) begin
			node_q  <= '0;
			lvl_q   <= LVL_W'(KEY_BITS - 1);
			fresh_q <= 1'b0;
		end else if (cmd.ex) begin
			node_q  <= nxt;
			fresh_q <= alloc;
			if (!last) begin
				lvl_q <= lvl_q - LVL_W'(1);
			end
		end
		if (cmd.pub) begin
			best_q <= cmd.pub_ans ? ans_nx : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfree_q    <= FREE_W'(1);
			root_l0_q  <= '0;
			root_l1_q  <= '0;
			root_c0_q  <= '0;
			root_c1_q  <= '0;
			root_cnt_q <= '0;
		end else if (cmd.clear) begin
			nfree_q    <= FREE_W'(1);
			root_l0_q  <= '0;
			root_l1_q  <= '0;
			root_c0_q  <= '0;
			root_c1_q  <= '0;
			root_cnt_q <= '0;
		end else begin
			if (cmd.restart && cmd.root_inc) begin
				root_cnt_q <= root_cnt_q + COUNT_BITS'(1);
			end else if (cmd.restart && cmd.root_dec) begin
				root_cnt_q <= root_cnt_q - COUNT_BITS'(1);
			end
			if (wr && is_root) begin
				root_l0_q <= n_l0;
				root_l1_q <= n_l1;
				root_c0_q <= n_c0;
				root_c1_q <= n_c1;
			end
			if (cmd.ex && alloc) begin
				nfree_q <= nfree_q + FREE_W'(1);
			end
		end
	end

	assign sts.walk_end   = last || stop;
	assign sts.root_empty = (root_cnt_q == '0);
	assign sts.root_full  = (root_cnt_q == '1);
	assign sts.pool_fail  = (SUM_W'(nfree_q) + SUM_W'(miss_q)) > SUM_W'(POOL_NODES);
	assign sts.absent     = absent_q;
	assign best_xor       = best_q;

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q != '0 && SUM_W'(nfree_q) <= SUM_W'(POOL_NODES))
		else $error("free pointer out of range");
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ex && alloc) |-> SUM_W'(nfree_q) < SUM_W'(POOL_NODES))
		else $error("allocation past end of pool");
	a_root_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (root_cnt_q == '0 && nfree_q == FREE_W'(1)))
		else $error("clear did not empty the trie");

endmodule

// File: src/bmx_ctrl.sv
// bmx_ctrl: operation sequencer - probe, update and query walks, result register and status code.
// Depends on bmx_pkg; drives bmx_dp through cmd_t and reads its sts_t.
module bmx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bmx_pkg::op_t   req_opcode,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bmx_pkg::stat_t rsp_status,
	output bmx_pkg::cmd_t  cmd,
	input  bmx_pkg::sts_t  sts
);
	import bmx_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_EX   = 2'd2;
	localparam logic [1:0] S_CHK  = 2'd3;

	logic [1:0] state_q, state_d;
	mode_t      mode_q, mode_d;
	stat_t      status_q, status_d;
	logic       valid_q, fin;
	logic       accept;

	assign req_ready  = (state_q == S_IDLE) && !valid_q;
	assign accept     = req_valid && req_ready;
	assign rsp_valid  = valid_q;
	assign rsp_status = status_q;

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		status_d = status_q;
		fin      = 1'b0;
		cmd      = '0;
		cmd.mode = mode_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (req_opcode)
						OP_INSERT: begin
							if (sts.root_full) begin
								fin      = 1'b1;
								status_d = STAT_FULL;
							end else begin
								mode_d  = M_PROBE_INS;
								state_d = S_RD;
							end
						end
						OP_REMOVE: begin
							mode_d  = M_PROBE_REM;
							state_d = S_RD;
						end
						OP_QUERY: begin
							if (sts.root_empty) begin
								fin      = 1'b1;
								status_d = STAT_EMPTY;
							end else begin
								mode_d  = M_QUERY;
								state_d = S_RD;
							end
						end
						default: begin
							cmd.clear = 1'b1;
							fin       = 1'b1;
							status_d  = STAT_OK;
						end
					endcase
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EX;
			end
			S_EX: begin
				cmd.ex = 1'b1;
				if (!sts.walk_end) begin
					state_d = S_RD;
				end else if (mode_q == M_PROBE_INS || mode_q == M_PROBE_REM) begin
					state_d = S_CHK;
				end else begin
					fin         = 1'b1;
					status_d    = STAT_OK;
					cmd.pub_ans = (mode_q == M_QUERY);
					state_d     = S_IDLE;
				end
			end
			S_CHK: begin
				if (mode_q == M_PROBE_INS) begin
					if (sts.pool_fail) begin
						fin      = 1'b1;
						status_d = STAT_FULL;
						state_d  = S_IDLE;
					end else begin
						cmd.restart  = 1'b1;
						cmd.root_inc = 1'b1;
						mode_d       = M_UPD_INS;
						state_d      = S_RD;
					end
				end else begin
					if (sts.absent) begin
						fin      = 1'b1;
						status_d = STAT_ABSENT;
						state_d  = S_IDLE;
					end else begin
						cmd.restart  = 1'b1;
						cmd.root_dec = 1'b1;
						mode_d       = M_UPD_REM;
						state_d      = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.pub = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= M_QUERY;
			status_q <= STAT_OK;
			valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			status_q <= status_d;
			if (fin) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> state_q == S_IDLE)
		else $error("result pending while walk active");
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (valid_q || state_q != S_IDLE))
		else $error("accepted word dropped");
	a_chk_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> (mode_q == M_PROBE_INS || mode_q == M_PROBE_REM))
		else $error("check state outside a probe");

endmodule

// File: src/binary_trie_max_xor_top.sv
// Channel | Dir | Payload            | Handshake
// req     | in  | opcode, key        | valid/ready
// rsp     | out | best_xor, status   | valid/ready
// Clear, query on an empty trie and insert at full root count: result 1 cycle after accept.
// Other words walk the trie bit by bit, S_RD then S_EX per key bit (registered node read).
// Query: one walk; remove and insert: probe walk, check, and update walk if the check passes.
// arst_n empties the trie at once; no clearing pass. One word in flight; req stalls until
// the previous result is taken.
module binary_trie_max_xor_top #(
	parameter int KEY_BITS   = 31,
	parameter int POOL_NODES = 4096,
	parameter int COUNT_BITS = 16
) (
	input logic              clk,
	input logic              arst_n,
	bmx_req_if.sink          req,
	bmx_rsp_if.source        rsp
);
	import bmx_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bmx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_opcode (req.opcode),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.cmd        (cmd),
		.sts        (sts)
	);

	bmx_dp #(
		.KEY_BITS   (KEY_BITS),
		.POOL_NODES (POOL_NODES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.key      (req.key),
		.best_xor (rsp.best_xor)
	);

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for binary_trie_max_xor_top (insert, remove, max-XOR query,
// clear). A scoreboard class predicts each result from a private trie and checks each response.
// Depends on bmx_pkg, bmx_req_if, bmx_rsp_if and the block itself.
`timescale 1ns / 1ps

import bmx_pkg::*;

class trie_scoreboard;
	localparam int KB = 31;
	localparam int POOL = 4096;
	localparam int CMAX = 65535;

	int unsigned links[POOL][2];
	int unsigned counts[POOL];
	int unsigned next_node;
	logic [30:0] exp_xor[$];
	stat_t exp_stat[$];
	int mismatches;

	function new();
		mismatches = 0;
		wipe();
	endfunction

	function void wipe();
		foreach (counts[i]) begin
			counts[i] = 0;
			links[i][0] = 0;
			links[i][1] = 0;
		end
		next_node = 1;
	endfunction

	function stat_t add_key(logic [30:0] k);
		int unsigned n, nx, lack;
		if (counts[0] >= CMAX)
			return STAT_FULL;
		n = 0;
		lack = 0;
		for (int lv = KB - 1; lv >= 0; lv--) begin
			nx = links[n][k[lv]];
			if (nx == 0) begin
				lack = lv + 1;
				break;
			end
			n = nx;
		end
		if (next_node + lack > POOL)
			return STAT_FULL;
		n = 0;
		counts[0]++;
		for (int lv = KB - 1; lv >= 0; lv--) begin
			nx = links[n][k[lv]];
			if (nx == 0) begin
				nx = next_node++;
				links[n][k[lv]] = nx;
				links[nx][0] = 0;
				links[nx][1] = 0;
				counts[nx] = 0;
			end
			n = nx;
			counts[n]++;
		end
		return STAT_OK;
	endfunction

	function stat_t drop_key(logic [30:0] k);
		int unsigned n;
		n = 0;
		for (int lv = KB - 1; lv >= 0; lv--) begin
			n = links[n][k[lv]];
			if (n == 0)
				return STAT_ABSENT;
		end
		if (counts[n] == 0)
			return STAT_ABSENT;
		n = 0;
		counts[0]--;
		for (int lv = KB - 1; lv >= 0; lv--) begin
			n = links[n][k[lv]];
			counts[n]--;
		end
		return STAT_OK;
	endfunction

	function stat_t best_match(logic [30:0] k, output logic [30:0] best);
		int unsigned n, nx;
		logic w;
		best = '0;
		if (counts[0] == 0)
			return STAT_EMPTY;
		n = 0;
		for (int lv = KB - 1; lv >= 0; lv--) begin
			w = ~k[lv];
			nx = links[n][w];
			if (nx != 0 && counts[nx] != 0)
				best[lv] = 1'b1;
			else
				nx = links[n][~w];
			n = nx;
			if (n == 0)
				break;
		end
		return STAT_OK;
	endfunction

	function void note_word(op_t op, logic [30:0] k);
		logic [30:0] b;
		stat_t s;
		b = '0;
		case (op)
			OP_INSERT: s = add_key(k);
			OP_REMOVE: s = drop_key(k);
			OP_QUERY: s = best_match(k, b);
			default: begin
				wipe();
				s = STAT_OK;
			end
		endcase
		exp_xor.push_back(b);
		exp_stat.push_back(s);
	endfunction

	function void check_word(logic [30:0] b, logic [1:0] s);
		logic [30:0] eb;
		stat_t es;
		if (exp_xor.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result best_xor=%0h status=%0d", b, s);
			return;
		end
		eb = exp_xor.pop_front();
		es = exp_stat.pop_front();
		if (b !== eb || s !== es) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: best_xor exp %0h got %0h, status exp %0d got %0d",
					eb, b, es, s);
		end
	endfunction

	function int pending();
		return exp_xor.size();
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int idle_cycles;
	trie_scoreboard sb;
	logic [30:0] key_pool[$];

	bmx_req_if #(.KEY_BITS(31)) req ();
	bmx_rsp_if #(.KEY_BITS(31)) rsp ();

	binary_trie_max_xor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		sb = new();
		req.valid = 1'b0;
		req.opcode = OP_INSERT;
		req.key = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_word(req.opcode, req.key);
			if (rsp.valid && rsp.ready)
				sb.check_word(rsp.best_xor, rsp.status);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase, mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			phase = $urandom_range(0, 999);
			mode = (phase < 300) ? 0 : (phase < 700) ? 1 : 2;
			repeat ($urandom_range(20, 200)) begin
				case (mode)
					0: rsp.ready = 1'b1;
					1: rsp.ready = ($urandom_range(0, 3) != 0);
					default: rsp.ready = ($urandom_range(0, 4) == 0);
				endcase
				@(negedge clk);
			end
		end
	end

	task automatic send_word(op_t op, logic [30:0] k);
		req.valid = 1'b1;
		req.opcode = op;
		req.key = k;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [30:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (key_pool.size() != 0 && r < 6)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (r < 8)
			return 31'($urandom_range(0, 255) << $urandom_range(0, 23));
		return 31'($urandom() & 32'h7fffffff);
	endfunction

	task automatic random_word();
		int r;
		op_t op;
		logic [30:0] k;
		r = $urandom_range(0, 99);
		op = (r < 40) ? OP_INSERT : (r < 65) ? OP_REMOVE : (r < 99) ? OP_QUERY : OP_CLEAR;
		k = pick_key();
		if (op == OP_INSERT && key_pool.size() < 64)
			key_pool.push_back(k);
		if (op == OP_CLEAR)
			key_pool.delete();
		send_word(op, k);
	endtask

	initial begin
		int sent;
		@(posedge arst_n);
		@(negedge clk);
		send_word(OP_QUERY, 31'h0);
		send_word(OP_REMOVE, 31'h7fffffff);
		send_word(OP_INSERT, 31'h0);
		send_word(OP_QUERY, 31'h0);
		send_word(OP_QUERY, 31'h7fffffff);
		send_word(OP_INSERT, 31'h7fffffff);
		send_word(OP_INSERT, 31'h7fffffff);
		send_word(OP_QUERY, 31'h0);
		send_word(OP_QUERY, 31'h2aaaaaaa);
		send_word(OP_REMOVE, 31'h7fffffff);
		send_word(OP_REMOVE, 31'h55555555);
		send_word(OP_REMOVE, 31'h7ffffffe);
		send_word(OP_QUERY, 31'h55555555);
		send_word(OP_REMOVE, 31'h0);
		send_word(OP_REMOVE, 31'h0);
		send_word(OP_QUERY, 31'h1);
		send_word(OP_CLEAR, 31'h7fffffff);
		send_word(OP_QUERY, 31'h7fffffff);
		drain();
		// exhaust the node pool with spread keys, then probe and clear
		for (int i = 0; i < 180; i++)
			send_word(OP_INSERT, 31'($urandom() & 32'h7fffffff));
		send_word(OP_QUERY, 31'h12345678);
		send_word(OP_CLEAR, 31'h0);
		sent = 0;
		while (sent < 1450) begin
			repeat ($urandom_range(1, 30)) begin
				random_word();
				sent++;
			end
			if ($urandom_range(0, 19) == 0)
				drain();
			else
				repeat ($urandom_range(0, 40)) @(negedge clk);
		end
		drain();
		repeat (200) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// File: files.f
src/bmx_pkg.sv
src/bmx_req_if.sv
src/bmx_rsp_if.sv
src/bmx_dp.sv
src/bmx_ctrl.sv
src/binary_trie_max_xor_top.sv
verif/tb_top.sv
